@@ rtl/qte_pkg.sv @@
// shared types, constants and the cordic angle table for the quaternion converter
`timescale 1ns / 1ps
package qte_pkg;

   // defaults for the top-level parameters
   localparam int CORDIC_STEPS_DEF   = 16;
   localparam int INTERNAL_WIDTH_DEF = 24;

   // datapath widths set by the 16-bit q14 inputs
   localparam int PROD_W = 32;   // one product of two components
   localparam int OP_W   = 34;   // signed atan2 operand
   localparam int MAG_W  = 34;   // magnitude of an atan2 operand
   localparam int NORM_W = 33;   // sum of four squares
   localparam int LEG_W  = 31;   // quarter norm, asin legs and root
   localparam int RAD_W  = 61;   // radicand of the cosine leg
   localparam int ANG_W  = 40;   // angle in nano-degrees, signed
   localparam int OUT_W  = 12;   // angle in tenths of a degree

   // pipeline depths of the fixed units
   localparam int SQRT_STEPS = (RAD_W + 1) / 2;
   localparam int TENTHS_LAT = 3;

   // angle constants in nano-degrees
   localparam logic [63:0] NANO_PER_RAD = 64'd57295779513;
   localparam logic signed [ANG_W-1:0] NANO_DEG90  = ANG_W'(64'd90000000000);
   localparam logic signed [ANG_W-1:0] NANO_DEG180 = ANG_W'(64'd180000000000);
   localparam logic signed [ANG_W-1:0] NANO_DEG360 = ANG_W'(64'd360000000000);

   // tenths conversion: |v| / 1e8 = (|v| >> 8) / 390625, by reciprocal
   localparam int          DIV_PRE_SHIFT = 8;
   localparam int          DIV_U_W       = 31;
   localparam logic [63:0] RECIP_DIV     = 64'd390625;
   localparam int          RECIP_SHIFT   = 50;
   localparam logic [31:0] RECIP_MUL     =
      32'(((64'd1 << RECIP_SHIFT) + RECIP_DIV - 64'd1) / RECIP_DIV);

   // arctangent of 2^-i for the first sixteen steps, nano-degrees
   localparam logic [63:0] ATAN_NANO [16] = '{
      64'd45000000000, 64'd26565051177, 64'd14036243468, 64'd7125016349,
      64'd3576334375,  64'd1789910608,  64'd895173710,   64'd447614171,
      64'd223810500,   64'd111905677,   64'd55952892,    64'd27976453,
      64'd13988227,    64'd6994114,     64'd3497057,     64'd1748528
   };

   // configuration register indexes
   localparam int CSR_IDX_W = 1;
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_USE_Y_AXIS  = 1'b0,
      CSR_INVERT_ROLL = 1'b1
   } csr_index_type;

   // request and response payloads
   typedef struct packed {
      logic signed [15:0] quat_real;
      logic signed [15:0] quat_i;
      logic signed [15:0] quat_j;
      logic signed [15:0] quat_k;
   } req_type;

   typedef struct packed {
      logic        [OUT_W-1:0] heading_tenths;
      logic signed [OUT_W-1:0] pitch_tenths;
      logic signed [OUT_W-1:0] roll_tenths;
      logic                    degenerate;
   } rsp_type;

   // rotation angle of cordic step idx
   function automatic logic signed [ANG_W-1:0] step_angle(input int idx);
      logic [3:0] sel;
      sel = 4'(idx);
      if (idx < 16) begin
         return ANG_W'(ATAN_NANO[sel]);
      end
      return ANG_W'(NANO_PER_RAD >> idx);
   endfunction

   // cycles through one cordic unit
   function automatic int cordic_lat(input int steps);
      return steps + 3;
   endfunction

endpackage

@@ rtl/qte_isqrt.sv @@
// pipelined integer square root, one result bit per stage
`timescale 1ns / 1ps
module qte_isqrt (
   input  logic                            clock,
   input  logic                            en,
   input  logic [qte_pkg::RAD_W-1:0]       rad_in,
   output logic [qte_pkg::LEG_W-1:0]       root_out
);

   localparam int N    = qte_pkg::SQRT_STEPS;
   localparam int RW   = qte_pkg::RAD_W;
   localparam int RESW = qte_pkg::RAD_W + 1;

   logic [RW-1:0]   rem_ff [N];
   logic [RESW-1:0] res_ff [N];

   // one digit step per stage, test bit walks down by powers of four
   for (genvar gk = 0; gk < N; gk++) begin : g_step
      logic [RW-1:0]   rem_cur;
      logic [RESW-1:0] res_cur;
      logic [RESW-1:0] trial;
      logic [RW-1:0]   rem_in;
      logic [RESW-1:0] res_in;
      localparam logic [RESW-1:0] BIT = RESW'(1) << (2 * (N - 1 - gk));

      if (gk == 0) begin : g_first
         assign rem_cur = rad_in;
         assign res_cur = '0;
      end else begin : g_next
         assign rem_cur = rem_ff[gk-1];
         assign res_cur = res_ff[gk-1];
      end

      always_comb begin
         trial = res_cur + BIT;
         if ({1'b0, rem_cur} >= trial) begin
            rem_in = rem_cur - trial[RW-1:0];
            res_in = (res_cur >> 1) + BIT;
         end else begin
            rem_in = rem_cur;
            res_in = res_cur >> 1;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[gk] <= rem_in;
            res_ff[gk] <= res_in;
         end
      end
   end

   assign root_out = res_ff[N-1][qte_pkg::LEG_W-1:0];

endmodule

@@ rtl/qte_cordic.sv @@
// pipelined vectoring cordic giving atan2(y, x) in nano-degrees
`timescale 1ns / 1ps
module qte_cordic #(
   parameter int CORDIC_STEPS   = qte_pkg::CORDIC_STEPS_DEF,
   parameter int INTERNAL_WIDTH = qte_pkg::INTERNAL_WIDTH_DEF
) (
   input  logic                              clock,
   input  logic                              en,
   input  logic signed [qte_pkg::OP_W-1:0]   y_in,
   input  logic signed [qte_pkg::OP_W-1:0]   x_in,
   output logic signed [qte_pkg::ANG_W-1:0]  angle_out
);

   localparam int CW      = INTERNAL_WIDTH + 2;
   localparam int TOP_BIT = INTERNAL_WIDTH - 3;
   localparam int MW      = qte_pkg::MAG_W;
   localparam int PW      = $clog2(MW);
   localparam int SW      = MW + CW;
   localparam int AW      = qte_pkg::ANG_W;

   // magnitudes, leading one and quadrant flags
   logic [MW-1:0] ax_in, ay_in, m_in;
   logic [PW-1:0] p_in;
   logic [MW-1:0] ax_ff, ay_ff;
   logic [PW-1:0] p_ff;
   logic          xneg_ff, yneg_ff, zero_ff;

   always_comb begin
      ax_in = MW'(x_in < 0 ? -x_in : x_in);
      ay_in = MW'(y_in < 0 ? -y_in : y_in);
      m_in  = (ax_in > ay_in) ? ax_in : ay_in;
      p_in  = '0;
      for (int k = 0; k < MW; k++) begin
         if (m_in[k]) begin
            p_in = PW'(k);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ax_ff   <= ax_in;
         ay_ff   <= ay_in;
         p_ff    <= p_in;
         xneg_ff <= (x_in < 0);
         yneg_ff <= (y_in < 0);
         zero_ff <= (m_in == '0);
      end
   end

   // common shift puts the larger magnitude just below the top guard bits
   logic signed [CW-1:0] cx_ff [CORDIC_STEPS+1];
   logic signed [CW-1:0] cy_ff [CORDIC_STEPS+1];
   logic signed [AW-1:0] z_ff  [CORDIC_STEPS+1];
   logic                 xn_ff [CORDIC_STEPS+1];
   logic                 yn_ff [CORDIC_STEPS+1];
   logic                 zr_ff [CORDIC_STEPS+1];
   logic [SW-1:0]        tx, ty;

   always_comb begin
      if (int'(p_ff) > TOP_BIT) begin
         tx = SW'(ax_ff) >> (int'(p_ff) - TOP_BIT);
         ty = SW'(ay_ff) >> (int'(p_ff) - TOP_BIT);
      end else begin
         tx = SW'(ax_ff) << (TOP_BIT - int'(p_ff));
         ty = SW'(ay_ff) << (TOP_BIT - int'(p_ff));
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cx_ff[0] <= signed'(tx[CW-1:0]);
         cy_ff[0] <= signed'(ty[CW-1:0]);
         z_ff[0]  <= '0;
         xn_ff[0] <= xneg_ff;
         yn_ff[0] <= yneg_ff;
         zr_ff[0] <= zero_ff;
      end
   end

   // one micro-rotation per stage, driving y towards zero
   for (genvar gi = 0; gi < CORDIC_STEPS; gi++) begin : g_iter
      localparam logic signed [AW-1:0] STEP = qte_pkg::step_angle(gi);
      always_ff @(posedge clock) begin
         if (en) begin
            if (cy_ff[gi] >= 0) begin
               cx_ff[gi+1] <= cx_ff[gi] + (cy_ff[gi] >>> gi);
               cy_ff[gi+1] <= cy_ff[gi] - (cx_ff[gi] >>> gi);
               z_ff[gi+1]  <= z_ff[gi] + STEP;
            end else begin
               cx_ff[gi+1] <= cx_ff[gi] - (cy_ff[gi] >>> gi);
               cy_ff[gi+1] <= cy_ff[gi] + (cx_ff[gi] >>> gi);
               z_ff[gi+1]  <= z_ff[gi] - STEP;
            end
            xn_ff[gi+1] <= xn_ff[gi];
            yn_ff[gi+1] <= yn_ff[gi];
            zr_ff[gi+1] <= zr_ff[gi];
         end
      end
   end

   // clamp to the first quadrant, then restore the quadrant
   logic signed [AW-1:0] zc, zq, angle_in, angle_ff;

   always_comb begin
      zc = z_ff[CORDIC_STEPS];
      if (zc < 0) begin
         zc = '0;
      end
      if (zc > qte_pkg::NANO_DEG90) begin
         zc = qte_pkg::NANO_DEG90;
      end
      zq = xn_ff[CORDIC_STEPS] ? (qte_pkg::NANO_DEG180 - zc) : zc;
      if (zr_ff[CORDIC_STEPS]) begin
         angle_in = '0;
      end else if (yn_ff[CORDIC_STEPS]) begin
         angle_in = -zq;
      end else begin
         angle_in = zq;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         angle_ff <= angle_in;
      end
   end

   assign angle_out = angle_ff;

endmodule

@@ rtl/qte_tenths.sv @@
// nano-degrees to tenths of a degree, truncated toward zero
`timescale 1ns / 1ps
module qte_tenths (
   input  logic                               clock,
   input  logic                               en,
   input  logic signed [qte_pkg::ANG_W-1:0]   angle_in,
   output logic signed [qte_pkg::OUT_W-1:0]   tenths_out
);

   localparam int UW = qte_pkg::DIV_U_W;
   localparam int PW = qte_pkg::DIV_U_W + 32;

   logic [qte_pkg::ANG_W-1:0] mag;
   logic [UW-1:0]             u_ff;
   logic                      neg1_ff, neg2_ff;
   logic [PW-1:0]             prod_ff;
   logic [qte_pkg::OUT_W-1:0] q;
   logic signed [qte_pkg::OUT_W-1:0] tenths_ff;

   // magnitude and pre-shift by the power-of-two factor of the divisor
   assign mag = qte_pkg::ANG_W'(angle_in < 0 ? -angle_in : angle_in);

   always_ff @(posedge clock) begin
      if (en) begin
         u_ff    <= mag[qte_pkg::DIV_PRE_SHIFT +: UW];
         neg1_ff <= (angle_in < 0);
      end
   end

   // reciprocal multiply
   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= PW'(u_ff) * PW'(qte_pkg::RECIP_MUL);
         neg2_ff <= neg1_ff;
      end
   end

   // quotient and sign
   assign q = prod_ff[qte_pkg::RECIP_SHIFT +: qte_pkg::OUT_W];

   always_ff @(posedge clock) begin
      if (en) begin
         tenths_ff <= neg2_ff ? -signed'(q) : signed'(q);
      end
   end

   assign tenths_out = tenths_ff;

endmodule

@@ rtl/quaternion_to_euler_angles_top.sv @@
// top level of the quaternion to heading, pitch and roll converter
`timescale 1ns / 1ps
// Takes one q14 quaternion per request on req_data (valid/ready) and returns
// heading, pitch and roll in tenths of a degree on rsp_data (valid/ready),
// one response per request, in order.
// From request accept to rsp_valid a request passes the input register,
// which loads at the accept edge, then the product, sum, asin-leg and
// radicand registers, 31 square-root stages, CORDIC_STEPS + 3 cordic
// stages, the tenths conversion registers and the response register.
// Throughput is one request per cycle while no response is held; the
// three cordic units run side by side, one step per stage.
// When the receiver stalls, the whole pipeline holds and req_ready drops
// while a response is waiting; nothing is lost or repeated.
// Synchronous reset empties the pipeline and clears use_y_axis and
// invert_roll. The csr_ port writes a register; write it only while no
// request is in flight.
// A zero quaternion gives zero angles with degenerate set.
module quaternion_to_euler_angles_top #(
   parameter int CORDIC_STEPS   = qte_pkg::CORDIC_STEPS_DEF,
   parameter int INTERNAL_WIDTH = qte_pkg::INTERNAL_WIDTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  qte_pkg::req_type                  req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output qte_pkg::rsp_type                  rsp_data,
   input  logic                              csr_we,
   input  logic [qte_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic                              csr_wdata
);

   localparam int OPW   = qte_pkg::OP_W;
   localparam int PRW   = qte_pkg::PROD_W;
   localparam int LW    = qte_pkg::LEG_W;
   localparam int AW    = qte_pkg::ANG_W;
   localparam int OW    = qte_pkg::OUT_W;
   localparam int SQL   = qte_pkg::SQRT_STEPS;
   localparam int CL    = qte_pkg::cordic_lat(CORDIC_STEPS);
   localparam int TL    = qte_pkg::TENTHS_LAT;
   localparam int TOTAL = 5 + SQL + CL + TL;

   logic en;
   logic rsp_valid_ff;
   logic use_y_axis_ff, invert_roll_ff;

   // whole pipeline advances unless a response is held
   assign en        = !rsp_valid_ff || rsp_ready;
   assign req_ready = en;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         use_y_axis_ff  <= 1'b0;
         invert_roll_ff <= 1'b0;
      end else if (csr_we) begin
         unique case (qte_pkg::csr_index_type'(csr_index))
            qte_pkg::CSR_USE_Y_AXIS:  use_y_axis_ff  <= csr_wdata;
            qte_pkg::CSR_INVERT_ROLL: invert_roll_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // valid bits travel alongside every stage
   logic [TOTAL-1:0] v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[TOTAL-2:0], req_valid};
      end
   end

   // input register
   qte_pkg::req_type in_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         in_ff <= req_data;
      end
   end

   // squares and cross products
   logic signed [PRW-1:0] sr_ff, si_ff, sj_ff, sk_ff;
   logic signed [PRW-1:0] pij_ff, pkr_ff, pik_ff, pjr_ff, pjk_ff, pir_ff;
   logic signed [PRW-1:0] er, ei, ej, ek;

   assign er = PRW'(in_ff.quat_real);
   assign ei = PRW'(in_ff.quat_i);
   assign ej = PRW'(in_ff.quat_j);
   assign ek = PRW'(in_ff.quat_k);

   always_ff @(posedge clock) begin
      if (en) begin
         sr_ff  <= er * er;
         si_ff  <= ei * ei;
         sj_ff  <= ej * ej;
         sk_ff  <= ek * ek;
         pij_ff <= ei * ej;
         pkr_ff <= ek * er;
         pik_ff <= ei * ek;
         pjr_ff <= ej * er;
         pjk_ff <= ej * ek;
         pir_ff <= ei * er;
      end
   end

   // norm and the three angle terms
   logic signed [OPW-1:0] xr, xi, xj, xk, norm_s;
   logic [qte_pkg::NORM_W-1:0] norm_ff;
   logic signed [OPW-1:0] yaw_y_ff, yaw_x_ff, asin_a_ff, atan_y_ff, atan_x_ff;
   logic degen2_ff;

   assign xr     = OPW'(sr_ff);
   assign xi     = OPW'(si_ff);
   assign xj     = OPW'(sj_ff);
   assign xk     = OPW'(sk_ff);
   assign norm_s = xr + xi + xj + xk;

   always_ff @(posedge clock) begin
      if (en) begin
         norm_ff   <= norm_s[qte_pkg::NORM_W-1:0];
         degen2_ff <= (norm_s == '0);
         yaw_y_ff  <= (OPW'(pij_ff) + OPW'(pkr_ff)) <<< 1;
         yaw_x_ff  <= xr + xi - xj - xk;
         asin_a_ff <= (OPW'(pjr_ff) - OPW'(pik_ff)) <<< 1;
         atan_y_ff <= (OPW'(pjk_ff) + OPW'(pir_ff)) <<< 1;
         atan_x_ff <= xr - xi - xj + xk;
      end
   end

   // asin legs: saturation test, quarter values, sine leg
   logic [qte_pkg::MAG_W-1:0] mag_a;
   logic [LW-1:0]   n2, a2;
   logic            sat_in;
   logic [LW-1:0]   dif_ff;
   logic [LW:0]     sm_ff;
   logic            sat3_ff, neg3_ff, degen3_ff;
   logic signed [OPW-1:0] sy3_ff, yaw_y3_ff, yaw_x3_ff, atan_y3_ff, atan_x3_ff;

   assign mag_a  = qte_pkg::MAG_W'(asin_a_ff < 0 ? -asin_a_ff : asin_a_ff);
   assign sat_in = (mag_a >= qte_pkg::MAG_W'(norm_ff));
   assign n2     = norm_ff[qte_pkg::NORM_W-1:2];
   assign a2     = mag_a[2 +: LW];

   always_ff @(posedge clock) begin
      if (en) begin
         dif_ff     <= sat_in ? '0 : (n2 - a2);
         sm_ff      <= (LW+1)'(n2) + (LW+1)'(a2);
         sat3_ff    <= sat_in;
         neg3_ff    <= (asin_a_ff < 0);
         degen3_ff  <= degen2_ff;
         sy3_ff     <= (asin_a_ff < 0) ? -OPW'(a2) : OPW'(a2);
         yaw_y3_ff  <= yaw_y_ff;
         yaw_x3_ff  <= yaw_x_ff;
         atan_y3_ff <= atan_y_ff;
         atan_x3_ff <= atan_x_ff;
      end
   end

   // radicand of the cosine leg
   typedef struct packed {
      logic signed [OPW-1:0] yaw_y;
      logic signed [OPW-1:0] yaw_x;
      logic signed [OPW-1:0] atan_y;
      logic signed [OPW-1:0] atan_x;
      logic signed [OPW-1:0] sy;
      logic                  sat;
      logic                  neg;
      logic                  degen;
   } sq_side_type;

   logic [2*LW:0]             prod;
   logic [qte_pkg::RAD_W-1:0] rad_ff;
   sq_side_type               side4_ff;

   assign prod = (2*LW+1)'(dif_ff) * (2*LW+1)'(sm_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         rad_ff         <= prod[qte_pkg::RAD_W-1:0];
         side4_ff.yaw_y  <= yaw_y3_ff;
         side4_ff.yaw_x  <= yaw_x3_ff;
         side4_ff.atan_y <= atan_y3_ff;
         side4_ff.atan_x <= atan_x3_ff;
         side4_ff.sy     <= sy3_ff;
         side4_ff.sat    <= sat3_ff;
         side4_ff.neg    <= neg3_ff;
         side4_ff.degen  <= degen3_ff;
      end
   end

   // cosine leg, with the other operands delayed to match
   logic [LW-1:0] leg;
   sq_side_type   sq_line_ff [SQL];

   qte_isqrt u_isqrt (
      .clock    (clock),
      .en       (en),
      .rad_in   (rad_ff),
      .root_out (leg)
   );

   always_ff @(posedge clock) begin
      if (en) begin
         sq_line_ff[0] <= side4_ff;
         for (int k = 1; k < SQL; k++) begin
            sq_line_ff[k] <= sq_line_ff[k-1];
         end
      end
   end

   // three atan2 units side by side
   sq_side_type sq_out;
   logic signed [AW-1:0] yaw_c, asin_c, atan_c;

   assign sq_out = sq_line_ff[SQL-1];

   qte_cordic #(
      .CORDIC_STEPS   (CORDIC_STEPS),
      .INTERNAL_WIDTH (INTERNAL_WIDTH)
   ) u_cordic_yaw (
      .clock     (clock),
      .en        (en),
      .y_in      (sq_out.yaw_y),
      .x_in      (sq_out.yaw_x),
      .angle_out (yaw_c)
   );

   qte_cordic #(
      .CORDIC_STEPS   (CORDIC_STEPS),
      .INTERNAL_WIDTH (INTERNAL_WIDTH)
   ) u_cordic_asin (
      .clock     (clock),
      .en        (en),
      .y_in      (sq_out.sy),
      .x_in      (OPW'(leg)),
      .angle_out (asin_c)
   );

   qte_cordic #(
      .CORDIC_STEPS   (CORDIC_STEPS),
      .INTERNAL_WIDTH (INTERNAL_WIDTH)
   ) u_cordic_atan (
      .clock     (clock),
      .en        (en),
      .y_in      (sq_out.atan_y),
      .x_in      (sq_out.atan_x),
      .angle_out (atan_c)
   );

   // saturation and zero-norm flags follow the cordic units
   typedef struct packed {
      logic sat;
      logic neg;
      logic degen;
   } cd_side_type;

   cd_side_type cd_line_ff [CL];

   always_ff @(posedge clock) begin
      if (en) begin
         cd_line_ff[0] <= '{sat: sq_out.sat, neg: sq_out.neg, degen: sq_out.degen};
         for (int k = 1; k < CL; k++) begin
            cd_line_ff[k] <= cd_line_ff[k-1];
         end
      end
   end

   // yaw wrap and asin saturation
   cd_side_type          cd_out;
   logic signed [AW-1:0] yaw_n, yaw_ang, asin_ang;

   assign cd_out  = cd_line_ff[CL-1];
   assign yaw_n   = -yaw_c;
   assign yaw_ang = (yaw_n < 0) ? (yaw_n + qte_pkg::NANO_DEG360) : yaw_n;

   always_comb begin
      if (cd_out.sat) begin
         asin_ang = cd_out.neg ? -qte_pkg::NANO_DEG90 : qte_pkg::NANO_DEG90;
      end else begin
         asin_ang = asin_c;
      end
   end

   // conversion to tenths
   logic signed [OW-1:0] yaw_t, asin_t, atan_t;
   logic                 dg_line_ff [TL];

   qte_tenths u_tenths_yaw (
      .clock      (clock),
      .en         (en),
      .angle_in   (yaw_ang),
      .tenths_out (yaw_t)
   );

   qte_tenths u_tenths_asin (
      .clock      (clock),
      .en         (en),
      .angle_in   (asin_ang),
      .tenths_out (asin_t)
   );

   qte_tenths u_tenths_atan (
      .clock      (clock),
      .en         (en),
      .angle_in   (atan_c),
      .tenths_out (atan_t)
   );

   always_ff @(posedge clock) begin
      if (en) begin
         dg_line_ff[0] <= cd_out.degen;
         for (int k = 1; k < TL; k++) begin
            dg_line_ff[k] <= dg_line_ff[k-1];
         end
      end
   end

   // axis selection, roll inversion and the response register
   qte_pkg::rsp_type     rsp_in, rsp_ff;
   logic signed [OW-1:0] roll_sel;

   always_comb begin
      rsp_in.heading_tenths = yaw_t;
      if (use_y_axis_ff) begin
         rsp_in.pitch_tenths = asin_t;
         roll_sel            = atan_t;
      end else begin
         rsp_in.pitch_tenths = atan_t;
         roll_sel            = asin_t;
      end
      rsp_in.roll_tenths = invert_roll_ff ? -roll_sel : roll_sel;
      rsp_in.degenerate  = 1'b0;
      if (dg_line_ff[TL-1]) begin
         rsp_in = '{heading_tenths: '0, pitch_tenths: '0, roll_tenths: '0,
                    degenerate: 1'b1};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= v_ff[TOTAL-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // heading stays inside one turn
   a_heading_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ff.heading_tenths <= OW'(3600)))
      else $error("heading out of range");

   // tilt angles stay within half a turn
   a_tilt_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((rsp_ff.pitch_tenths <= 12'sd1800)
                        && (rsp_ff.pitch_tenths >= -12'sd1800)
                        && (rsp_ff.roll_tenths <= 12'sd1800)
                        && (rsp_ff.roll_tenths >= -12'sd1800)))
      else $error("tilt angle out of range");

   // a zero quaternion gives all-zero angles
   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.degenerate) |-> ((rsp_ff.heading_tenths == '0)
         && (rsp_ff.pitch_tenths == '0) && (rsp_ff.roll_tenths == '0)))
      else $error("degenerate response with non-zero angle");

   // a held response freezes the valid bits of every stage and stays valid
   a_hold_tail: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |=> ($stable(v_ff) && rsp_valid_ff))
      else $error("pipeline moved during stall");

endmodule
